/* sv/multi_slot_oneshot_timer_top_assert.svh */
// Assertion macros for the multi-slot one-shot timer.
// Used by multi_slot_oneshot_timer_top; expands to nothing when SYNTH is defined.
`ifndef MULTI_SLOT_ONESHOT_TIMER_TOP_ASSERT_SVH
`define MULTI_SLOT_ONESHOT_TIMER_TOP_ASSERT_SVH
`ifndef SYNTH
`define MSOT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
`define MSOT_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);
`else
`define MSOT_ASSERT(lbl, prop, msg)
`define MSOT_ASSERT_NEXT(lbl, cond, prop, msg)
`endif
`endif

/* sv/msot_pkg.sv */
// Package for the multi-slot one-shot timer: sizes, codes and the wrap distance.
// Used by multi_slot_oneshot_timer_top; no dependencies.
package msot_pkg;

    localparam int SLOT_COUNT = 8;
    localparam int SLOT_W     = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
    localparam int CNT_W      = $clog2(SLOT_COUNT + 1);
    localparam int ISS_W      = $clog2(SLOT_COUNT + 1);

    localparam logic [1:0] REQ_TICK   = 2'd0;
    localparam logic [1:0] REQ_START  = 2'd1;
    localparam logic [1:0] REQ_CANCEL = 2'd2;
    localparam logic [1:0] REQ_SET    = 2'd3;

    localparam logic [1:0] STAT_OK   = 2'd0;
    localparam logic [1:0] STAT_FULL = 2'd1;
    localparam logic [1:0] STAT_BAD  = 2'd2;

    localparam logic REG_TICK_STEP   = 1'b0;
    localparam logic REG_PAST_WINDOW = 1'b1;

    localparam logic [15:0] TICK_STEP_RST   = 16'd1;
    localparam logic [14:0] PAST_WINDOW_RST = 15'd16384;

    function automatic logic signed [16:0] wrap_dist(
        input logic [15:0] t,
        input logic [15:0] c,
        input logic [14:0] pw
    );
        logic [15:0]        a;
        logic [15:0]        b;
        logic signed [16:0] d;
        a = t - c;
        b = c - t;
        d = $signed({a[15], a});
        if (d > $signed({2'b00, pw})) begin
            d = $signed({b[15], b});
        end
        return d;
    endfunction

    function automatic logic is_elapsed(input logic signed [16:0] d);
        return d[16] || (d == 17'sd0);
    endfunction

endpackage

/* sv/msot_ram.sv */
// Generic single-write, single-read synchronous RAM with a registered read port.
// Holds the slot deadlines of the multi-slot one-shot timer; no dependencies.
module msot_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8,
    parameter int AW    = 3
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

/* sv/multi_slot_oneshot_timer_top.sv */
// Top level of the multi-slot one-shot timer: request sequencer and slot scan.
// Depends on msot_pkg, msot_ram and multi_slot_oneshot_timer_top_assert.svh.
//
// Requests arrive on the s_ stream: s_tuser carries the request kind (tick,
// start, cancel, set time), s_tdata the duration, slot index and new time.
// Every request yields exactly one transaction on the m_ stream with the
// status, granted slot, fired mask, time after the request and active count.
// Registers tick_step and past_window are written through cfg_we, cfg_addr
// and cfg_wdata; the user must do so while the block is idle (not enforced).
// Slot deadlines live in a RAM read one slot per cycle. A start, a real
// cancel or a set time scans all SLOT_COUNT slots before its result goes
// to the response state; a firing tick checks the nearest deadline first
// and then scans. A quiet tick, a full start or a bad cancel skips the
// scan. One request is in work at a time; s_tready is high only while
// the sequencer is idle.
// The result sits in an output register; the next request is accepted while
// it waits, and the sequencer holds its finished result until m_tready frees
// the register. Synchronous reset frees every slot, zeroes time, nearest
// deadline and count, and restores the register defaults.
module multi_slot_oneshot_timer_top
    import msot_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic        cfg_addr,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    // s_tdata: duration[15:0], slot_index[19:16], load_time[35:20], zero fill.
    input  logic [39:0] s_tdata,
    // s_tuser: req_type[1:0].
    input  logic [1:0]  s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // m_tdata: status[1:0], granted_slot[5:2], fired_mask[21:6],
    // time_now[37:22], active_slots[42:38], zero fill.
    output logic [47:0] m_tdata
);

    `include "multi_slot_oneshot_timer_top_assert.svh"

    typedef enum logic [1:0] {IDLE, CHECK, SCAN, RESP} state_t;

    state_t                  state_reg;
    logic [15:0]             tick_step_reg;
    logic [14:0]             past_window_reg;
    logic [15:0]             clock_reg;
    logic [15:0]             nearest_reg;
    logic [SLOT_COUNT-1:0]   busy_reg;
    logic [CNT_W-1:0]        count_reg;
    logic [1:0]              status_reg;
    logic [SLOT_W-1:0]       granted_reg;
    logic [SLOT_COUNT-1:0]   fired_reg;
    logic                    fire_mode_reg;
    logic [ISS_W-1:0]        iss_cnt_reg;
    logic                    cmp_vld_reg;
    logic [SLOT_W-1:0]       cmp_idx_reg;
    logic                    found_reg;
    logic signed [16:0]      best_reg;
    logic [15:0]             at_reg;
    logic                    m_tvalid_reg;
    logic [47:0]             m_tdata_reg;

    logic [1:0]              s_req;
    logic [15:0]             s_duration;
    logic [3:0]              s_slot_index;
    logic [15:0]             s_load_time;
    logic                    s_accept;
    logic                    free_found;
    logic [SLOT_W-1:0]       free_idx;
    logic                    idx_ok;
    logic                    wr_en;
    logic                    rd_en;
    logic [SLOT_W-1:0]       rd_addr;
    logic [15:0]             rd_data;
    logic signed [16:0]      cmp_dist;
    logic                    cmp_elapsed;
    logic                    out_free;

    assign s_req        = s_tuser;
    assign s_duration   = s_tdata[15:0];
    assign s_slot_index = s_tdata[19:16];
    assign s_load_time  = s_tdata[35:20];
    assign s_tready     = (state_reg == IDLE);
    assign s_accept     = s_tvalid && s_tready;
    assign m_tvalid     = m_tvalid_reg;
    assign m_tdata      = m_tdata_reg;
    assign out_free     = !m_tvalid_reg || m_tready;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
            if (!busy_reg[i]) begin
                free_found = 1'b1;
                free_idx   = SLOT_W'(i);
            end
        end
    end

    assign idx_ok = ({1'b0, s_slot_index} < 5'(SLOT_COUNT))
                    && busy_reg[s_slot_index[SLOT_W-1:0]];

    assign wr_en   = s_accept && (s_req == REQ_START) && free_found;
    assign rd_en   = (state_reg == SCAN) && (iss_cnt_reg < ISS_W'(SLOT_COUNT));
    assign rd_addr = iss_cnt_reg[SLOT_W-1:0];

    msot_ram #(
        .WIDTH (16),
        .DEPTH (SLOT_COUNT),
        .AW    (SLOT_W)
    ) u_deadline_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (free_idx),
        .wr_data (clock_reg + s_duration),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    assign cmp_dist    = wrap_dist(rd_data, clock_reg, past_window_reg);
    assign cmp_elapsed = is_elapsed(cmp_dist);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= IDLE;
            tick_step_reg   <= TICK_STEP_RST;
            past_window_reg <= PAST_WINDOW_RST;
            clock_reg       <= '0;
            nearest_reg     <= '0;
            busy_reg        <= '0;
            count_reg       <= '0;
            fire_mode_reg   <= 1'b0;
            iss_cnt_reg     <= '0;
            cmp_vld_reg     <= 1'b0;
            found_reg       <= 1'b0;
            m_tvalid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                case (cfg_addr)
                    REG_TICK_STEP:   tick_step_reg   <= cfg_wdata;
                    REG_PAST_WINDOW: past_window_reg <= cfg_wdata[14:0];
                    default:         ;
                endcase
            end
            if (m_tvalid_reg && m_tready && (state_reg != RESP)) begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                IDLE: begin
                    if (s_accept) begin
                        status_reg    <= STAT_OK;
                        granted_reg   <= '0;
                        fired_reg     <= '0;
                        fire_mode_reg <= 1'b0;
                        iss_cnt_reg   <= '0;
                        cmp_vld_reg   <= 1'b0;
                        found_reg     <= 1'b0;
                        case (s_req)
                            REQ_TICK: begin
                                clock_reg <= clock_reg + tick_step_reg;
                                state_reg <= CHECK;
                            end
                            REQ_START: begin
                                if (free_found) begin
                                    busy_reg[free_idx] <= 1'b1;
                                    count_reg          <= count_reg + 1'b1;
                                    granted_reg        <= free_idx;
                                    state_reg          <= SCAN;
                                end else begin
                                    status_reg <= STAT_FULL;
                                    state_reg  <= RESP;
                                end
                            end
                            REQ_CANCEL: begin
                                if (idx_ok) begin
                                    busy_reg[s_slot_index[SLOT_W-1:0]] <= 1'b0;
                                    count_reg <= count_reg - 1'b1;
                                    state_reg <= SCAN;
                                end else begin
                                    status_reg <= STAT_BAD;
                                    state_reg  <= RESP;
                                end
                            end
                            REQ_SET: begin
                                clock_reg <= s_load_time;
                                state_reg <= SCAN;
                            end
                            default: state_reg <= RESP;
                        endcase
                    end
                end
                CHECK: begin
                    if ((count_reg != '0)
                        && is_elapsed(wrap_dist(nearest_reg, clock_reg, past_window_reg)))
                    begin
                        fire_mode_reg <= 1'b1;
                        state_reg     <= SCAN;
                    end else begin
                        state_reg <= RESP;
                    end
                end
                SCAN: begin
                    cmp_vld_reg <= rd_en;
                    cmp_idx_reg <= rd_addr;
                    if (rd_en) begin
                        iss_cnt_reg <= iss_cnt_reg + 1'b1;
                    end
                    if (cmp_vld_reg && busy_reg[cmp_idx_reg]) begin
                        if (fire_mode_reg && cmp_elapsed) begin
                            busy_reg[cmp_idx_reg]  <= 1'b0;
                            fired_reg[cmp_idx_reg] <= 1'b1;
                            count_reg              <= count_reg - 1'b1;
                        end else if (!found_reg || (cmp_dist < best_reg)) begin
                            found_reg <= 1'b1;
                            best_reg  <= cmp_dist;
                            at_reg    <= rd_data;
                        end
                    end
                    if (!rd_en && !cmp_vld_reg) begin
                        if (found_reg) begin
                            nearest_reg <= at_reg;
                        end
                        state_reg <= RESP;
                    end
                end
                RESP: begin
                    if (out_free) begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {5'd0,
                                         5'(count_reg),
                                         clock_reg,
                                         16'(fired_reg),
                                         4'(granted_reg),
                                         status_reg};
                        state_reg    <= IDLE;
                    end
                end
                default: state_reg <= IDLE;
            endcase
        end
    end

    `MSOT_ASSERT(a_count_match, 32'(count_reg) == $countones(busy_reg), "busy count mismatch")
    `MSOT_ASSERT(a_scan_bound, (state_reg == SCAN) |-> (iss_cnt_reg <= ISS_W'(SLOT_COUNT)), "scan overrun")
    `MSOT_ASSERT(a_fire_ok, (m_tvalid_reg && (m_tdata_reg[21:6] != 16'd0)) |-> (m_tdata_reg[5:0] == {4'd0, STAT_OK}), "fired mask on non-tick result")
    `MSOT_ASSERT_NEXT(a_accept_busy, s_accept, state_reg != IDLE, "accepted request left no work")

endmodule

/* tb/msot_timer_check_pkg.sv */
// Request and result types plus the scoreboard for the multi-slot one-shot timer bench.
// Depends on msot_pkg for the slot count, request kinds and status codes.
package msot_timer_check_pkg;
    import msot_pkg::*;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] duration;
        logic [3:0]  slot_index;
        logic [15:0] load_time;
    } timer_req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [3:0]  granted_slot;
        logic [15:0] fired_mask;
        logic [15:0] time_now;
        logic [4:0]  active_slots;
    } timer_result_t;

    class timer_scoreboard;
        logic [15:0]   step;
        logic [14:0]   window;
        logic [15:0]   now;
        logic [15:0]   nearest;
        logic [15:0]   deadline [SLOT_COUNT];
        bit            armed [SLOT_COUNT];
        int unsigned   running;
        timer_result_t awaited [$];
        int unsigned   errors;
        int unsigned   requests;
        int unsigned   firing_ticks;
        int unsigned   full_starts;
        int unsigned   refused_cancels;

        function new();
            step = TICK_STEP_RST;
            window = PAST_WINDOW_RST;
            now = '0;
            nearest = '0;
            running = 0;
            errors = 0;
            requests = 0;
            firing_ticks = 0;
            full_starts = 0;
            refused_cancels = 0;
            for (int i = 0; i < SLOT_COUNT; i++) begin
                deadline[i] = '0;
                armed[i] = 0;
            end
        endfunction

        function void set_step(logic [15:0] value);
            step = value;
        endfunction

        function void set_window(logic [14:0] value);
            window = value;
        endfunction

        function int pending();
            return awaited.size();
        endfunction

        function int signed_gap(logic [15:0] t, logic [15:0] c);
            logic [15:0] fwd;
            logic [15:0] back;
            int          d;
            fwd = t - c;
            back = c - t;
            d = $signed(fwd);
            if (d > int'(window)) begin
                d = $signed(back);
            end
            return d;
        endfunction

        function void refresh_nearest();
            int best;
            int d;
            best = 65537;
            if (running == 0) begin
                return;
            end
            for (int i = 0; i < SLOT_COUNT; i++) begin
                if (armed[i]) begin
                    d = signed_gap(deadline[i], now);
                    if (d < best) begin
                        best = d;
                        nearest = deadline[i];
                    end
                end
            end
        endfunction

        function void note_request(timer_req_t rq);
            timer_result_t res;
            int            got;
            res = '0;
            got = -1;
            requests++;
            case (rq.kind)
                REQ_TICK: begin
                    now = now + step;
                    if (running > 0 && signed_gap(nearest, now) <= 0) begin
                        for (int i = 0; i < SLOT_COUNT; i++) begin
                            if (armed[i] && signed_gap(deadline[i], now) <= 0) begin
                                res.fired_mask[i] = 1'b1;
                                armed[i] = 0;
                                running--;
                            end
                        end
                        refresh_nearest();
                    end
                    if (res.fired_mask != 0) begin
                        firing_ticks++;
                    end
                end
                REQ_START: begin
                    for (int i = SLOT_COUNT - 1; i >= 0; i--) begin
                        if (!armed[i]) begin
                            got = i;
                        end
                    end
                    if (got < 0) begin
                        res.status = STAT_FULL;
                        full_starts++;
                    end else begin
                        armed[got] = 1;
                        running++;
                        deadline[got] = now + rq.duration;
                        res.granted_slot = got[3:0];
                        refresh_nearest();
                    end
                end
                REQ_CANCEL: begin
                    if (rq.slot_index >= SLOT_COUNT || !armed[rq.slot_index]) begin
                        res.status = STAT_BAD;
                        refused_cancels++;
                    end else begin
                        armed[rq.slot_index] = 0;
                        running--;
                        refresh_nearest();
                    end
                end
                default: begin
                    now = rq.load_time;
                    refresh_nearest();
                end
            endcase
            res.time_now = now;
            res.active_slots = running[4:0];
            awaited.push_back(res);
        endfunction

        function void compare(string field, int unsigned want, int unsigned got);
            if (want != got) begin
                $error("%s: expected %0d, got %0d", field, want, got);
                errors++;
            end
        endfunction

        function void check_result(logic [47:0] word);
            timer_result_t want;
            if (awaited.size() == 0) begin
                $error("result transaction arrived with no request outstanding");
                errors++;
                return;
            end
            want = awaited.pop_front();
            compare("status", want.status, word[1:0]);
            compare("granted_slot", want.granted_slot, word[5:2]);
            compare("fired_mask", want.fired_mask, word[21:6]);
            compare("time_now", want.time_now, word[37:22]);
            compare("active_slots", want.active_slots, word[42:38]);
        endfunction
    endclass

endpackage

/* tb/tb_multi_slot_oneshot_timer_top.sv */
// Testbench for multi_slot_oneshot_timer_top: directed and random requests under
// several register settings with random stalls. Depends on msot_pkg and msot_timer_check_pkg.
module tb_multi_slot_oneshot_timer_top;
    timeunit 1ns;
    timeprecision 1ps;
    import msot_pkg::*;
    import msot_timer_check_pkg::*;

    localparam int CYCLE_LIMIT = 600000;

    logic        aclk = 1'b0;
    logic        aresetn;
    logic        cfg_we;
    logic        cfg_addr;
    logic [15:0] cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [39:0] s_tdata;
    logic [1:0]  s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [47:0] m_tdata;

    timer_scoreboard board;
    bit              steady;
    logic [15:0]     cur_step;
    int unsigned     cycle_count = 0;
    int              settings_seen;

    multi_slot_oneshot_timer_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #5 aclk = ~aclk;

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("multi_slot_oneshot_timer_top verification failed");
            $finish;
        end
    end

    initial begin
        int hold;
        hold = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (steady) begin
                m_tready = 1'b1;
            end else if (hold > 0) begin
                hold--;
            end else if (m_tready) begin
                m_tready = 1'b0;
                case ($urandom_range(0, 19))
                    0: hold = $urandom_range(20, 50);
                    1, 2, 3, 4, 5: hold = $urandom_range(4, 10);
                    default: hold = $urandom_range(0, 2);
                endcase
            end else begin
                m_tready = 1'b1;
                hold = $urandom_range(0, 12);
            end
        end
    end

    initial begin
        forever begin
            @(posedge aclk);
            if (aresetn && m_tvalid && m_tready) begin
                board.check_result(m_tdata);
            end
        end
    end

    function automatic int pick_gap();
        int k;
        k = $urandom_range(0, 19);
        if (steady || k < 10) begin
            return 0;
        end else if (k < 18) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(10, 40);
    endfunction

    task automatic push_request(input timer_req_t rq);
        int gap;
        @(negedge aclk);
        s_tvalid = 1'b1;
        s_tuser = rq.kind;
        s_tdata = {4'b0, rq.load_time, rq.slot_index, rq.duration};
        do @(posedge aclk); while (!s_tready);
        board.note_request(rq);
        gap = pick_gap();
        if (gap > 0) begin
            @(negedge aclk);
            s_tvalid = 1'b0;
            repeat (gap - 1) @(negedge aclk);
        end
    endtask

    task automatic put(input logic [1:0] kind, input logic [15:0] dur,
                       input logic [3:0] idx, input logic [15:0] t);
        timer_req_t rq;
        rq.kind = kind;
        rq.duration = dur;
        rq.slot_index = idx;
        rq.load_time = t;
        push_request(rq);
    endtask

    function automatic timer_req_t random_request();
        timer_req_t rq;
        int         k;
        rq.duration = 16'($urandom);
        rq.slot_index = 4'($urandom);
        rq.load_time = 16'($urandom);
        k = $urandom_range(0, 99);
        if (k < 45) begin
            rq.kind = REQ_TICK;
        end else if (k < 72) begin
            rq.kind = REQ_START;
            k = $urandom_range(0, 9);
            if (k < 6 && cur_step != 0) begin
                rq.duration = 16'($urandom_range(0, 40) * cur_step);
            end else if (k < 8) begin
                rq.duration = 16'($urandom_range(0, 255));
            end
        end else if (k < 93) begin
            rq.kind = REQ_CANCEL;
            if ($urandom_range(0, 4) != 0) begin
                rq.slot_index = 4'($urandom_range(0, SLOT_COUNT - 1));
            end
        end else begin
            rq.kind = REQ_SET;
            if ($urandom_range(0, 1) == 0) begin
                rq.load_time = 16'($urandom_range(0, 255));
            end
        end
        return rq;
    endfunction

    task automatic settle();
        while (board.pending() > 0) @(posedge aclk);
        repeat (24) @(posedge aclk);
    endtask

    task automatic write_reg(input logic addr, input logic [15:0] value);
        @(negedge aclk);
        cfg_we = 1'b1;
        cfg_addr = addr;
        cfg_wdata = value;
        @(negedge aclk);
        cfg_we = 1'b0;
        if (addr == REG_TICK_STEP) begin
            board.set_step(value);
            cur_step = value;
        end else begin
            board.set_window(value[14:0]);
        end
    endtask

    initial begin
        logic [15:0] nstep;
        logic [14:0] nwin;
        aresetn = 1'b0;
        cfg_we = 1'b0;
        cfg_addr = 1'b0;
        cfg_wdata = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = '0;
        steady = 0;
        cur_step = TICK_STEP_RST;
        settings_seen = 1;
        board = new();
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (int ph = 0; ph < 7; ph++) begin
            if (ph > 0) begin
                settle();
                case (ph)
                    1: begin nstep = 16'd3; nwin = 15'h7FFF; end
                    2: begin nstep = 16'd0; nwin = 15'd0; end
                    3: begin nstep = 16'hFFFF; nwin = 15'd100; end
                    4: begin nstep = 16'd1; nwin = 15'd0; end
                    5: begin
                        nstep = 16'($urandom_range(2, 40));
                        nwin = 15'($urandom_range(0, 32767));
                    end
                    default: begin nstep = TICK_STEP_RST; nwin = PAST_WINDOW_RST; end
                endcase
                write_reg(REG_TICK_STEP, nstep);
                write_reg(REG_PAST_WINDOW, {1'b0, nwin});
                settings_seen++;
            end
            steady = (ph == 2 || ph == 5);
            if (ph == 0) begin
                put(REQ_TICK, 16'hFFFF, 4'hF, 16'hFFFF);
                put(REQ_CANCEL, 16'd0, 4'd3, 16'd0);
                put(REQ_CANCEL, 16'd0, 4'd15, 16'd0);
                put(REQ_SET, 16'd0, 4'd0, 16'hFFF0);
                put(REQ_START, 16'd0, 4'd0, 16'd0);
                put(REQ_START, 16'hFFFF, 4'd0, 16'd0);
                put(REQ_START, 16'd5, 4'd0, 16'd0);
                put(REQ_START, 16'd2, 4'd0, 16'd0);
                put(REQ_START, 16'h8000, 4'd0, 16'd0);
                put(REQ_START, 16'd3, 4'd0, 16'd0);
                put(REQ_START, 16'd1, 4'd0, 16'd0);
                put(REQ_START, 16'd100, 4'd0, 16'd0);
                put(REQ_START, 16'd9, 4'd0, 16'd0);
                put(REQ_CANCEL, 16'd0, 4'd2, 16'd0);
                put(REQ_START, 16'd7, 4'd0, 16'd0);
                put(REQ_CANCEL, 16'd0, 4'd9, 16'd0);
                repeat (4) put(REQ_TICK, 16'd0, 4'd0, 16'd0);
                put(REQ_SET, 16'd0, 4'd0, 16'd5);
                put(REQ_TICK, 16'd0, 4'd0, 16'd0);
                put(REQ_CANCEL, 16'd0, 4'd1, 16'd0);
            end
            repeat (128) push_request(random_request());
            @(negedge aclk);
            s_tvalid = 1'b0;
        end

        settle();
        $display("Ran %0d requests under %0d register settings.", board.requests,
                 settings_seen);
        $display("Ticks that fired timers: %0d, starts with no free slot: %0d, refused cancels: %0d.",
                 board.firing_ticks, board.full_starts, board.refused_cancels);
        if (board.errors == 0 && board.pending() == 0) begin
            $display("multi_slot_oneshot_timer_top verification clean");
        end else begin
            $display("multi_slot_oneshot_timer_top verification failed");
        end
        $finish;
    end

endmodule

/* files.f */
+incdir+sv
sv/msot_pkg.sv
sv/msot_ram.sv
sv/multi_slot_oneshot_timer_top.sv
tb/msot_timer_check_pkg.sv
tb/tb_multi_slot_oneshot_timer_top.sv
